[src/fla_pkg.sv]
// Shared types and constants for the free-list allocator.
package fla_pkg;

  // Payload field widths
  localparam int CMD_W   = 2;
  localparam int FREE_W  = 10;
  localparam int ALLOC_W = 10;
  localparam int CFG_W   = 11;

  localparam int          POOL_DEPTH_DEF = 1024;
  localparam logic [CFG_W-1:0] POOL_SIZE_RST = 11'd1024;

  // Request command codes
  localparam logic [CMD_W-1:0] CMD_INIT  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_ALLOC = 2'd1;
  localparam logic [CMD_W-1:0] CMD_FREE  = 2'd2;

  // Controller to datapath
  typedef struct packed {
    logic capture;    // latch request, read link at head, clear walk counter
    logic walk_step;  // chain one entry during init
    logic commit;     // update head and load the result register
  } dp_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic init_zero;  // saturated pool size is zero
    logic init_last;  // walk counter is at the last chained entry
  } dp_sts_t;

endpackage

[src/fla_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module fla_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

[src/fla_dpath.sv]
// Datapath: pool size register, free-list head, link memory and result register.
module fla_dpath #(
  parameter int POOL_DEPTH = fla_pkg::POOL_DEPTH_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cfg_we,
  input  logic [fla_pkg::CFG_W-1:0]    cfg_wdata,
  input  logic [fla_pkg::CMD_W-1:0]    in_cmd,
  input  logic [fla_pkg::FREE_W-1:0]   in_free_index,
  input  fla_pkg::dp_cmd_t             cmd,
  output fla_pkg::dp_sts_t             sts,
  output logic [fla_pkg::ALLOC_W-1:0]  out_alloc_index,
  output logic                         out_granted,
  output logic                         out_pool_empty
);
  import fla_pkg::*;

  localparam int IDX_W  = $clog2(POOL_DEPTH);
  localparam int LINK_W = IDX_W + 1;            // {null, index}
  localparam int NW     = IDX_W + 1;            // holds POOL_DEPTH itself
  localparam int SW     = (NW > CFG_W) ? NW : CFG_W;
  localparam int CW     = ((IDX_W > FREE_W) ? IDX_W : FREE_W) + 1;

  logic [CFG_W-1:0]   pool_size_r;
  logic [IDX_W-1:0]   head_r, head_nxt;
  logic               head_null_r, head_null_nxt;
  logic [CMD_W-1:0]   cmd_r;
  logic [FREE_W-1:0]  idx_r;
  logic [IDX_W-1:0]   walk_r;
  logic [ALLOC_W-1:0] alloc_r, alloc_nxt;
  logic               grant_r, grant_nxt;
  logic               empty_r;

  logic [SW-1:0]      ps_ext;
  logic [NW-1:0]      n_sat;
  logic               idx_ok;
  logic [IDX_W-1:0]   idx_addr;

  logic               ram_we;
  logic [IDX_W-1:0]   ram_waddr;
  logic [LINK_W-1:0]  ram_wdata;
  logic [LINK_W-1:0]  ram_rdata;
  logic [LINK_W-1:0]  walk_link;

  // Pool size clamps to the store depth
  assign ps_ext = SW'(pool_size_r);
  assign n_sat  = (ps_ext > SW'(POOL_DEPTH)) ? NW'(POOL_DEPTH) : NW'(ps_ext);

  assign sts.init_zero = (n_sat == '0);
  assign sts.init_last = ({1'b0, walk_r} == (n_sat - NW'(1)));

  assign idx_ok   = (CW'(idx_r) < CW'(POOL_DEPTH));
  assign idx_addr = IDX_W'(idx_r);

  // Last chained entry ends the list
  assign walk_link = sts.init_last ? {1'b1, {IDX_W{1'b0}}}
                                   : {1'b0, walk_r + IDX_W'(1)};

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = idx_addr;
    ram_wdata = {head_null_r, head_r};
    if (cmd.walk_step) begin
      ram_we    = 1'b1;
      ram_waddr = walk_r;
      ram_wdata = walk_link;
    end else if (cmd.commit && (cmd_r == CMD_FREE) && idx_ok) begin
      ram_we    = 1'b1;
    end
  end

  fla_ram #(
    .WIDTH (LINK_W),
    .DEPTH (POOL_DEPTH)
  ) u_link_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (cmd.capture),
    .raddr (head_r),
    .rdata (ram_rdata)
  );

  always_comb begin
    head_nxt      = head_r;
    head_null_nxt = head_null_r;
    alloc_nxt     = '0;
    grant_nxt     = 1'b0;
    unique case (cmd_r)
      CMD_INIT: begin
        head_nxt      = '0;
        head_null_nxt = sts.init_zero;
      end
      CMD_ALLOC: begin
        if (!head_null_r) begin
          alloc_nxt     = ALLOC_W'(head_r);
          grant_nxt     = 1'b1;
          head_nxt      = ram_rdata[IDX_W-1:0];
          head_null_nxt = ram_rdata[LINK_W-1];
        end
      end
      CMD_FREE: begin
        if (idx_ok) begin
          head_nxt      = idx_addr;
          head_null_nxt = 1'b0;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pool_size_r <= POOL_SIZE_RST;
      head_r      <= '0;
      head_null_r <= 1'b1;
    end else begin
      if (cfg_we) begin
        pool_size_r <= cfg_wdata;
      end
      if (cmd.commit) begin
        head_r      <= head_nxt;
        head_null_r <= head_null_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      cmd_r  <= in_cmd;
      idx_r  <= in_free_index;
      walk_r <= '0;
    end else if (cmd.walk_step) begin
      walk_r <= walk_r + IDX_W'(1);
    end
    if (cmd.commit) begin
      alloc_r <= alloc_nxt;
      grant_r <= grant_nxt;
      empty_r <= head_null_nxt;
    end
  end

  assign out_alloc_index = alloc_r;
  assign out_granted     = grant_r;
  assign out_pool_empty  = empty_r;

endmodule

[src/fla_ctrl.sv]
// Controller: request sequencing and result handshake.
module fla_ctrl (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  input  logic [fla_pkg::CMD_W-1:0] in_cmd,
  output logic                      in_stall,
  output logic                      out_valid,
  input  logic                      out_stall,
  input  fla_pkg::dp_sts_t          sts,
  output fla_pkg::dp_cmd_t          cmd
);
  import fla_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE   = 3'b001,
    ST_WALK   = 3'b010,
    ST_COMMIT = 3'b100
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   slot_free;

  assign slot_free = !out_valid_r || !out_stall;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          if ((in_cmd == CMD_INIT) && !sts.init_zero) begin
            state_nxt = ST_WALK;
          end else begin
            state_nxt = ST_COMMIT;
          end
        end
      end
      ST_WALK: begin
        cmd.walk_step = 1'b1;
        if (sts.init_last) begin
          state_nxt = ST_COMMIT;
        end
      end
      ST_COMMIT: begin
        if (slot_free) begin
          cmd.commit = 1'b1;
          state_nxt  = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r && out_stall;
    if (cmd.commit) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_stall  = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;

  a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.capture |=> (state_r != ST_IDLE))
    else $error("accepted request did not leave idle");

  a_walk_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_WALK) && !sts.init_last |=> (state_r == ST_WALK))
    else $error("init walk ended early");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_stall |-> !cmd.commit)
    else $error("commit over a held result");

  a_valid_from_commit: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(cmd.commit))
    else $error("result valid without a commit");

endmodule

[src/free_list_allocator.sv]
// Free-list pool allocator: top level joining controller and datapath.
//
// Pool allocator over POOL_DEPTH entries kept as a singly linked free list in a
// one-write, one-read link RAM plus a head register. Allocate reads the link at
// the head in the accept cycle and free writes it in the commit cycle; init
// chains min(pool_size, POOL_DEPTH) entries before its commit, one RAM entry per
// cycle. No request is accepted until the current one has committed its result;
// a finished result sits in the output register, and a commit waits while that
// register is still held by out_stall. The link RAM needs no clearing after
// reset: the list starts empty and every link that can be read was written.
// pool_size is written through cfg_we/cfg_wdata; the user must write it only
// while the block is idle, as the block itself does not enforce this.
module free_list_allocator #(
  parameter int POOL_DEPTH = fla_pkg::POOL_DEPTH_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cfg_we,
  input  logic [fla_pkg::CFG_W-1:0]    cfg_wdata,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [fla_pkg::CMD_W-1:0]    in_cmd,
  input  logic [fla_pkg::FREE_W-1:0]   in_free_index,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [fla_pkg::ALLOC_W-1:0]  out_alloc_index,
  output logic                         out_granted,
  output logic                         out_pool_empty
);
  import fla_pkg::*;

  dp_cmd_t dp_cmd;
  dp_sts_t dp_sts;

  fla_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_cmd    (in_cmd),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (dp_sts),
    .cmd       (dp_cmd)
  );

  fla_dpath #(
    .POOL_DEPTH (POOL_DEPTH)
  ) u_dpath (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_we          (cfg_we),
    .cfg_wdata       (cfg_wdata),
    .in_cmd          (in_cmd),
    .in_free_index   (in_free_index),
    .cmd             (dp_cmd),
    .sts             (dp_sts),
    .out_alloc_index (out_alloc_index),
    .out_granted     (out_granted),
    .out_pool_empty  (out_pool_empty)
  );

endmodule

[tb/free_list_allocator_checker.sv]
// Checker for the free-list allocator: predicts each result and compares it.
`timescale 1ns / 100ps

module free_list_allocator_checker
  import fla_pkg::*;
#(
  parameter int POOL_DEPTH = POOL_DEPTH_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic [CFG_W-1:0]   cfg_wdata,
  input  logic               in_valid,
  input  logic               in_stall,
  input  logic [CMD_W-1:0]   in_cmd,
  input  logic [FREE_W-1:0]  in_free_index,
  input  logic               out_valid,
  input  logic               out_stall,
  input  logic [ALLOC_W-1:0] out_alloc_index,
  input  logic               out_granted,
  input  logic               out_pool_empty,
  output int                 fail_count,
  output int                 results_due
);

  typedef struct packed {
    logic [ALLOC_W-1:0] alloc_index;
    logic               granted;
    logic               pool_empty;
  } pool_reply_t;

  // Shadow free list: link per entry plus end-of-list flag, and the head
  int             link_to  [POOL_DEPTH];
  bit             link_end [POOL_DEPTH];
  int             head;
  bit             head_null;
  logic [CFG_W-1:0] pool_size;

  pool_reply_t    reply_q [$];

  task automatic predict_pool_op(input logic [CMD_W-1:0] cmd, input logic [FREE_W-1:0] idx,
                                 output pool_reply_t res);
    int n;
    res = '0;
    case (cmd)
      CMD_INIT: begin
        n = (int'(pool_size) > POOL_DEPTH) ? POOL_DEPTH : int'(pool_size);
        if (n == 0) begin
          head_null = 1'b1;
        end else begin
          for (int i = 0; i + 1 < n; i++) begin
            link_to[i]  = i + 1;
            link_end[i] = 1'b0;
          end
          link_to[n-1]  = 0;
          link_end[n-1] = 1'b1;
          head          = 0;
          head_null     = 1'b0;
        end
      end
      CMD_ALLOC: begin
        if (!head_null && head < POOL_DEPTH) begin
          res.alloc_index = head[ALLOC_W-1:0];
          res.granted     = 1'b1;
          head_null       = link_end[head];
          head            = link_to[head];
        end
      end
      CMD_FREE: begin
        if (int'(idx) < POOL_DEPTH) begin
          link_to[idx]  = head;
          link_end[idx] = head_null;
          head          = int'(idx);
          head_null     = 1'b0;
        end
      end
      default: ;  // unused code leaves the list alone
    endcase
    res.pool_empty = head_null;
  endtask

  task automatic check_field(input string name, input int want_v, input int got_v);
    if (want_v != got_v) begin
      $error("%s: expected %0d, got %0d", name, want_v, got_v);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    pool_reply_t want;
    if (!rst_n) begin
      head       = 0;
      head_null  = 1'b1;
      pool_size  = POOL_SIZE_RST;
      fail_count = 0;
      reply_q.delete();
    end else begin
      if (cfg_we) pool_size = cfg_wdata;
      if (in_valid && !in_stall) begin
        predict_pool_op(in_cmd, in_free_index, want);
        reply_q.push_back(want);
      end
      if (out_valid && !out_stall) begin
        if (reply_q.size() == 0) begin
          $error("result with no request outstanding: alloc_index %0d granted %0d empty %0d",
                 out_alloc_index, out_granted, out_pool_empty);
          fail_count++;
        end else begin
          want = reply_q.pop_front();
          check_field("alloc_index", int'(want.alloc_index), int'(out_alloc_index));
          check_field("granted", int'(want.granted), int'(out_granted));
          check_field("pool_empty", int'(want.pool_empty), int'(out_pool_empty));
        end
      end
    end
    results_due <= reply_q.size();
  end

endmodule

[tb/free_list_allocator_tb.sv]
// Testbench top for the free-list allocator: clock, reset, stimulus and verdict.
`timescale 1ns / 100ps

module free_list_allocator_tb;
  import fla_pkg::*;

  localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
  localparam int QUIET_LIMIT = 20000;

  logic               clk;
  logic               rst_n;
  logic               cfg_we;
  logic [CFG_W-1:0]   cfg_wdata;
  logic               in_valid;
  logic               in_stall;
  logic [CMD_W-1:0]   in_cmd;
  logic [FREE_W-1:0]  in_free_index;
  logic               out_valid;
  logic               out_stall;
  logic [ALLOC_W-1:0] out_alloc_index;
  logic               out_granted;
  logic               out_pool_empty;

  int fail_count;
  int results_due;
  int send_idle_pct;
  int stall_pct;
  int quiet_cycles;

  // Indices handed out and not yet returned; feeds well-formed frees
  logic [FREE_W-1:0] held [$];

  free_list_allocator DUT (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_we          (cfg_we),
    .cfg_wdata       (cfg_wdata),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_cmd          (in_cmd),
    .in_free_index   (in_free_index),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_alloc_index (out_alloc_index),
    .out_granted     (out_granted),
    .out_pool_empty  (out_pool_empty)
  );

  free_list_allocator_checker u_pool_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_we          (cfg_we),
    .cfg_wdata       (cfg_wdata),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_cmd          (in_cmd),
    .in_free_index   (in_free_index),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_alloc_index (out_alloc_index),
    .out_granted     (out_granted),
    .out_pool_empty  (out_pool_empty),
    .fail_count      (fail_count),
    .results_due     (results_due)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  always @(posedge clk) begin
    out_stall <= ($urandom_range(0, 99) < stall_pct);
  end

  // Outputs are stable at the falling edge, so this sees what the next edge accepts
  always @(negedge clk) begin
    if (rst_n && out_valid && !out_stall && out_granted) held.push_back(out_alloc_index);
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("free_list_allocator test failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Valid stays high on return; the next request or a drain decides what follows
  task automatic send_request(input logic [CMD_W-1:0] cmd, input logic [FREE_W-1:0] idx);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_cmd        <= cmd;
    in_free_index <= idx;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (results_due != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_pool_size(input logic [CFG_W-1:0] size);
    cfg_we    <= 1'b1;
    cfg_wdata <= size;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  task automatic random_request();
    int r;
    int pick;
    logic [FREE_W-1:0] idx;
    r   = $urandom_range(0, 99);
    idx = FREE_W'($urandom_range(0, 1023));
    if (r < 45) begin
      send_request(CMD_ALLOC, idx);
    end else if (r < 88) begin
      if (held.size() > 0 && $urandom_range(0, 99) < 80) begin
        pick = $urandom_range(0, held.size() - 1);
        idx  = held[pick];
        held.delete(pick);
      end
      send_request(CMD_FREE, idx);
    end else if (r < 95) begin
      held.delete();
      send_request(CMD_INIT, idx);
    end else begin
      send_request(CMD_UNUSED, idx);
    end
  endtask

  task automatic run_phase(input int send_pct, input int recv_pct, input int items);
    int sent;
    int seg;
    logic [CFG_W-1:0] size;
    sent          = 0;
    send_idle_pct = send_pct;
    stall_pct     = recv_pct;
    while (sent < items) begin
      wait_drained();
      // mostly small pools so the list runs dry often
      case ($urandom_range(0, 19))
        0:       size = '0;
        1:       size = 11'd1;
        2:       size = 11'd1024;
        3:       size = '1;
        4:       size = CFG_W'($urandom_range(0, 2047));
        default: size = CFG_W'($urandom_range(2, 24));
      endcase
      set_pool_size(size);
      held.delete();
      send_request(CMD_INIT, FREE_W'($urandom_range(0, 1023)));
      seg = $urandom_range(20, 80);
      repeat (seg) random_request();
      sent += seg + 1;
    end
  endtask

  initial begin
    rst_n         <= 1'b0;
    cfg_we        <= 1'b0;
    cfg_wdata     <= '0;
    in_valid      <= 1'b0;
    in_cmd        <= CMD_INIT;
    in_free_index <= '0;
    out_stall     <= 1'b0;
    send_idle_pct = 17;
    stall_pct     = 54;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Before any init: list empty, then a lone free and its allocate
    send_request(CMD_ALLOC, 10'd0);
    send_request(CMD_UNUSED, 10'd1023);
    send_request(CMD_FREE, 10'd1023);
    send_request(CMD_ALLOC, 10'd0);
    send_request(CMD_ALLOC, 10'd0);
    // Full pool at the reset size, then a double free that loops the list
    send_request(CMD_INIT, 10'd0);
    send_request(CMD_ALLOC, 10'd1023);
    send_request(CMD_FREE, 10'd0);
    send_request(CMD_FREE, 10'd0);
    send_request(CMD_ALLOC, 10'd0);
    send_request(CMD_ALLOC, 10'd0);
    wait_drained();
    // Zero pool size leaves the list empty
    set_pool_size('0);
    send_request(CMD_INIT, 10'd0);
    send_request(CMD_ALLOC, 10'd0);
    send_request(CMD_FREE, 10'd512);
    send_request(CMD_ALLOC, 10'd0);
    wait_drained();
    // Oversized pool saturates to the store depth
    set_pool_size('1);
    send_request(CMD_INIT, 10'd1023);
    send_request(CMD_ALLOC, 10'd0);
    send_request(CMD_FREE, 10'd1023);
    send_request(CMD_ALLOC, 10'd0);
    wait_drained();
    set_pool_size(11'd1);
    send_request(CMD_INIT, 10'd0);
    send_request(CMD_ALLOC, 10'd0);
    send_request(CMD_ALLOC, 10'd0);
    send_request(CMD_FREE, 10'd0);

    run_phase(17, 54, 583);
    run_phase(54, 17, 583);
    run_phase(0, 0, 584);
    wait_drained();

    if (fail_count == 0 && results_due == 0) begin
      $display("free_list_allocator test passed");
    end else begin
      $display("free_list_allocator test failed");
    end
    $finish;
  end

endmodule
